[hw/rtl/c_source_token_lexer_defines.svh]
// Assertion macros for the C source token lexer.
`ifndef C_SOURCE_TOKEN_LEXER_DEFINES_SVH
`define C_SOURCE_TOKEN_LEXER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSTL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CSTL_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CSTL_ASSERT_IMP(label, clk, rst_n, a, c)
`define CSTL_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[hw/rtl/cstl_pkg.sv]
// ----------------------------------------------------------------------------
// cstl_pkg
// Shared types and constants of the C source token lexer.
// ----------------------------------------------------------------------------
package cstl_pkg;
    localparam int unsigned TokenBytesDef = 63;

    typedef enum logic [3:0] {
        K_END = 4'd0, K_TEXT = 4'd1, K_PRE = 4'd2, K_HDR = 4'd3, K_KEY = 4'd4,
        K_NUM = 4'd5, K_STR = 4'd6, K_LINE = 4'd7, K_BLOCK = 4'd8, K_CHR = 4'd9
    } t_kind;

    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_DATA = 3'd1;
    localparam logic [2:0] P_OTHER = 3'd2;
    localparam logic [2:0] P_SYS = 3'd3;
    localparam logic [2:0] P_USER = 3'd4;

    // Keyword signature: length and up to 8 bytes packed little first.
    localparam int unsigned NumKw = 32;
    localparam logic [63:0] KwText [NumKw] = '{
        64'h0074736e6f63, 64'h656c6974616c6f76, 64'h6e7265747865, 64'h6f747561,
        64'h7265747369676572, 64'h636974617473, 64'h64656e676973,
        64'h64656e6769736e75, 64'h74726f6873, 64'h676e6f6c, 64'h656c62756f64,
        64'h72616863, 64'h746e69, 64'h74616f6c66, 64'h746375727473,
        64'h6e6f696e75, 64'h6d756e65, 64'h64696f76, 64'h66656465707974,
        64'h6f746f67, 64'h6e7275746572, 64'h65756e69746e6f63, 64'h6b61657262,
        64'h6669, 64'h65736c65, 64'h726f66, 64'h656c696877, 64'h6f64,
        64'h686374697773, 64'h65736163, 64'h746c7561666564, 64'h666f657a6973
    };
    localparam logic [3:0] KwLen [NumKw] = '{
        4'd5, 4'd8, 4'd6, 4'd4, 4'd8, 4'd6, 4'd6, 4'd8, 4'd5, 4'd4, 4'd6,
        4'd4, 4'd3, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd7, 4'd4, 4'd6, 4'd8,
        4'd5, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd4, 4'd7, 4'd6
    };
    localparam int unsigned NumKwData = 19;

    function automatic logic [2:0] kw_class(input logic [63:0] txt,
                                            input logic [5:0] len);
        logic [2:0] p;
        p = P_NONE;
        for (int i = NumKw - 1; i >= 0; i--) begin
            if ({2'b00, KwLen[i]} == len && KwText[i] == txt) begin
                p = (i < NumKwData) ? P_DATA : P_OTHER;
            end
        end
        return p;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_num_stop(input logic [7:0] b);
        return b inside {8'h09, 8'h20, 8'h3b, 8'h0a, 8'h2f, 8'h2b, 8'h2a, 8'h2d,
                         8'h25, 8'h3d, 8'h3c, 8'h3e, 8'h7e, 8'h26, 8'h2c, 8'h21,
                         8'h5e, 8'h7c, 8'h28, 8'h29, 8'h7b, 8'h5b, 8'h3a};
    endfunction
endpackage

[hw/rtl/cstl_text_ram.sv]
// ----------------------------------------------------------------------------
// cstl_text_ram
// Token byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cstl_text_ram #(
    parameter int unsigned DEPTH = 63,
    parameter int unsigned AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/c_source_token_lexer.sv]
// ----------------------------------------------------------------------------
// c_source_token_lexer
// Sorts C source bytes into tokens and emits each token byte by byte.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_src_byte and i_end_of_input.
// Output channel: o_valid / i_stall with one token byte per item, tagged with
// kind, property, length and a last flag; an empty token gives one item with
// o_byte_valid low.
// A byte that extends a token is taken without holding the input. A byte that
// closes a token holds the input while the token drains from the buffer
// memory: each byte is read through the registered read port of the buffer
// memory and then loaded into the output register.
// A closing byte that belongs to the next token is seen again in the cycle
// after the drain ends, and a slash followed by another byte stores the pair
// in the PH_SLASH and PH_PUT2 phases.
// Keyword matching uses a copy of the first eight token bytes and is
// combinational.
// Reset returns the lexer to idle with an empty buffer. When the receiver
// stalls, the output item holds and the drain pauses.
// ----------------------------------------------------------------------------
`include "c_source_token_lexer_defines.svh"
module c_source_token_lexer #(
    parameter int unsigned TOKEN_BYTES = cstl_pkg::TokenBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_src_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_token_kind,
    output logic [2:0] o_token_property,
    output logic [7:0] o_text_byte,
    output logic       o_byte_valid,
    output logic [5:0] o_token_length,
    output logic       o_last_of_token
);
    import cstl_pkg::*;
    localparam int unsigned AW = $clog2(TOKEN_BYTES);

    typedef enum logic [3:0] {
        M_IDLE, M_PRE, M_HDR, M_WORD, M_NUM, M_STR, M_LINE, M_BLOCK, M_CHR
    } t_mode;

    typedef enum logic [2:0] {
        PH_ACCEPT, PH_RETRY, PH_SLASH, PH_PUT2, PH_DRAIN
    } t_phase;

    t_mode       r_mode, n_mode;
    t_phase      r_ph, r_after, ph_after;
    logic [5:0]  r_cnt, n_cnt, cnt_w;
    logic        r_slash, n_slash, r_esc, n_esc, r_star, n_star;
    logic [63:0] r_head, n_head;
    logic [7:0]  r_b;
    logic [3:0]  r_dkind, gkind;
    logic [2:0]  r_dprop, gprop;
    logic [5:0]  r_dlen, r_didx;
    logic        r_rdv;

    logic [7:0]  src, wbyte, rdata;
    logic        step, put, we, go;
    logic        accept, out_free, ld_empty, ld_byte, d_last;

    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_ph != PH_ACCEPT);
    assign accept   = i_valid && !o_stall;
    assign step     = (accept && !i_end_of_input) || (r_ph == PH_RETRY);
    assign src      = (r_ph == PH_RETRY) ? r_b : i_src_byte;
    assign ld_empty = (r_ph == PH_DRAIN) && !r_rdv && (r_dlen == 6'd0);
    assign ld_byte  = (r_ph == PH_DRAIN) && r_rdv;
    assign d_last   = ld_empty || (r_didx + 6'd1 == r_dlen);

    cstl_text_ram #(.DEPTH(TOKEN_BYTES), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(wbyte),
        .i_raddr(r_didx[AW-1:0]), .o_rdata(rdata)
    );

    always_comb begin
        n_mode = r_mode; n_slash = r_slash; n_esc = r_esc; n_star = r_star;
        put = 1'b0; wbyte = src; go = 1'b0; gkind = K_END; gprop = P_NONE;
        ph_after = PH_ACCEPT;
        if (r_ph == PH_SLASH) begin
            put = 1'b1; wbyte = 8'h2f; ph_after = PH_PUT2;
        end else if (r_ph == PH_PUT2) begin
            put = 1'b1; wbyte = r_b;
        end else if (accept && i_end_of_input) begin
            put = r_slash; wbyte = 8'h2f; go = 1'b1; gkind = K_END;
            n_mode = M_IDLE; n_slash = 1'b0; n_esc = 1'b0; n_star = 1'b0;
        end else if (step) begin
            case (r_mode)
            M_IDLE: begin
                if (r_slash) begin
                    n_slash = 1'b0; ph_after = PH_SLASH;
                    if (src == 8'h2a || src == 8'h2f) begin
                        go = (r_cnt != 6'd0); gkind = K_TEXT;
                        n_mode = (src == 8'h2a) ? M_BLOCK : M_LINE; n_star = 1'b0;
                    end
                end else if (src == 8'h2f) begin
                    n_slash = 1'b1;
                end else if (src == 8'h27 || src == 8'h23 || src == 8'h22 ||
                             is_letter(src)) begin
                    if (r_cnt != 6'd0) begin
                        go = 1'b1; gkind = K_TEXT; ph_after = PH_RETRY;
                    end else begin
                        n_mode = (src == 8'h27) ? M_CHR : (src == 8'h23) ? M_PRE :
                                 (src == 8'h22) ? M_STR : M_WORD;
                        n_esc = 1'b0; put = 1'b1;
                    end
                end else begin
                    if (is_digit(src) && r_cnt == 6'd0) n_mode = M_NUM;
                    put = 1'b1;
                end
            end
            M_PRE: begin
                if (src == 8'h0a || src == 8'h3c || src == 8'h22) begin
                    go = 1'b1; gkind = K_PRE;
                    n_mode = (src == 8'h0a) ? M_IDLE : M_HDR;
                    ph_after = (src == 8'h3c) ? PH_ACCEPT : PH_RETRY;
                end else put = 1'b1;
            end
            M_HDR: begin
                if (src == 8'h3e) begin
                    go = 1'b1; gkind = K_HDR; gprop = P_SYS; n_mode = M_IDLE;
                end else begin
                    put = 1'b1;
                    if (src == 8'h22 && r_cnt != 6'd0) begin
                        go = 1'b1; gkind = K_HDR; gprop = P_USER; n_mode = M_IDLE;
                    end
                end
            end
            M_WORD: begin
                if (is_letter(src) || is_digit(src)) put = 1'b1;
                else begin
                    go = 1'b1; n_mode = M_IDLE; ph_after = PH_RETRY;
                    gprop = (r_cnt <= 6'd8) ? kw_class(r_head, r_cnt) : P_NONE;
                    gkind = (gprop != P_NONE) ? K_KEY : K_TEXT;
                end
            end
            M_NUM: begin
                if (is_num_stop(src)) begin
                    go = 1'b1; gkind = K_NUM; n_mode = M_IDLE; ph_after = PH_RETRY;
                end else put = 1'b1;
            end
            M_STR, M_CHR: begin
                put = 1'b1;
                if (r_esc) n_esc = 1'b0;
                else if (src == 8'h5c) n_esc = 1'b1;
                else if (src == ((r_mode == M_STR) ? 8'h22 : 8'h27)) begin
                    go = 1'b1; n_mode = M_IDLE;
                    gkind = (r_mode == M_STR) ? K_STR : K_CHR;
                end
            end
            M_LINE: begin
                put = 1'b1;
                if (src == 8'h0a) begin
                    go = 1'b1; gkind = K_LINE; n_mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                put = 1'b1;
                if (src == 8'h2f && r_star) begin
                    go = 1'b1; gkind = K_BLOCK; n_mode = M_IDLE; n_star = 1'b0;
                end else n_star = (src == 8'h2a);
            end
            default: ;
            endcase
        end
        we = put && (r_cnt < 6'(TOKEN_BYTES));
        cnt_w = r_cnt + {5'd0, we};
        n_cnt = go ? 6'd0 : cnt_w;
        n_head = r_head;
        if (we && r_cnt < 6'd8) n_head[{r_cnt[2:0], 3'b000} +: 8] = wbyte;
        if (go) n_head = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_ACCEPT; r_after <= PH_ACCEPT; r_mode <= M_IDLE; r_cnt <= '0;
            r_slash <= 1'b0; r_esc <= 1'b0; r_star <= 1'b0; r_head <= '0;
            r_b <= '0; r_dkind <= '0; r_dprop <= '0; r_dlen <= '0; r_didx <= '0;
            r_rdv <= 1'b0;
            o_valid <= 1'b0; o_token_kind <= '0; o_token_property <= '0;
            o_text_byte <= '0; o_byte_valid <= 1'b0; o_token_length <= '0;
            o_last_of_token <= 1'b0;
        end else begin
            r_mode <= n_mode; r_cnt <= n_cnt; r_slash <= n_slash;
            r_esc <= n_esc; r_star <= n_star; r_head <= n_head;
            if (step) r_b <= src;
            if (r_ph == PH_DRAIN) begin
                if (ld_byte || ld_empty) begin
                    if (out_free) begin
                        r_rdv <= 1'b0;
                        r_didx <= r_didx + 6'd1;
                        if (d_last) r_ph <= r_after;
                    end
                end else begin
                    r_rdv <= 1'b1;
                end
            end else if (go) begin
                r_ph <= PH_DRAIN; r_after <= ph_after;
                r_dkind <= gkind; r_dprop <= gprop; r_dlen <= cnt_w;
                r_didx <= '0; r_rdv <= 1'b0;
            end else begin
                r_ph <= ph_after;
            end
            if (out_free) begin
                o_valid <= ld_byte || ld_empty;
                if (ld_byte || ld_empty) begin
                    o_token_kind <= r_dkind; o_token_property <= r_dprop;
                    o_text_byte <= ld_byte ? rdata : 8'd0;
                    o_byte_valid <= ld_byte;
                    o_token_length <= r_dlen;
                    o_last_of_token <= d_last;
                end
            end
        end
    end

    `CSTL_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_ph != PH_ACCEPT, !accept)
    `CSTL_ASSERT_NXT(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 6'(TOKEN_BYTES))
    `CSTL_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, o_valid && !o_byte_valid,
                     o_last_of_token && o_token_length == 6'd0)
    `CSTL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
                     o_valid && $stable(o_text_byte))
endmodule
